// ===== rtl/core/bkis_pkg.sv =====
`timescale 1ns / 1ps
// Package for the batch key/index sorter: field widths, the stored entry
// type and the controller-to-datapath command word. No dependencies.
package bkis_pkg;

  localparam int HIGH_W    = 64;
  localparam int LOW_W     = 16;
  localparam int KEY_W     = HIGH_W + LOW_W;
  localparam int IDX_W     = 6;
  // fill count: holds 0 up to the largest batch of 64
  localparam int CNT_W     = 7;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 88;
  localparam int M_PAD_W   = M_TDATA_W - IDX_W - KEY_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;   // {high, low}: unsigned compare is byte order
  } entry_t;

  typedef struct packed {
    logic             load;   // write incoming key at cell 'count'
    logic             step;   // one odd-even transposition pass
    logic             phase;  // 0: pairs (0,1),(2,3)..  1: pairs (1,2),(3,4)..
    logic             shift;  // move every cell down one place
    logic [CNT_W-1:0] count;  // load address, or number of held keys
  } cmd_t;

endpackage

// ===== rtl/core/bkis_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: a row of entry cells with a compare-exchange unit between
// neighbors, indexed load and shift-out. Uses bkis_pkg.
module bkis_datapath #(
  parameter int BATCH = 64
) (
  input  logic                           clk,
  input  bkis_pkg::cmd_t                 cmd,
  input  logic [bkis_pkg::HIGH_W-1:0]    key_high,
  input  logic [bkis_pkg::LOW_W-1:0]     key_low,
  output bkis_pkg::entry_t               head
);

  localparam int ADDR_W = $clog2(BATCH);

  bkis_pkg::entry_t cells      [BATCH];
  bkis_pkg::entry_t cells_next [BATCH];

  always_comb begin
    for (int j = 0; j < BATCH; j++) begin
      cells_next[j] = cells[j];
    end
    if (cmd.load) begin
      cells_next[cmd.count[ADDR_W-1:0]] =
        '{idx: cmd.count[bkis_pkg::IDX_W-1:0], key: {key_high, key_low}};
    end
    if (cmd.step) begin
      // strict greater-than only: equal keys never pass each other
      for (int j = 0; j < BATCH - 1; j++) begin
        if ((j % 2) == int'(cmd.phase) &&
            bkis_pkg::CNT_W'(j + 1) < cmd.count &&
            cells[j].key > cells[j+1].key) begin
          cells_next[j]   = cells[j+1];
          cells_next[j+1] = cells[j];
        end
      end
    end
    if (cmd.shift) begin
      for (int j = 0; j < BATCH - 1; j++) begin
        cells_next[j] = cells[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < BATCH; j++) begin
      cells[j] <= cells_next[j];
    end
  end

  assign head = cells[0];

endmodule

// ===== rtl/core/bkis_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: load / sort / emit sequencer with fill and pass counters.
// Drives bkis_datapath through bkis_pkg::cmd_t.
module bkis_ctrl #(
  parameter int BATCH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic           m_tlast,
  output bkis_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [bkis_pkg::CNT_W-1:0] FULL = bkis_pkg::CNT_W'(BATCH);
  localparam logic [bkis_pkg::CNT_W-1:0] ONE  = bkis_pkg::CNT_W'(1);

  logic [1:0]                 state, state_next;
  logic [bkis_pkg::CNT_W-1:0] fill, fill_next;
  logic [bkis_pkg::CNT_W-1:0] pass, pass_next;
  logic                       s_acc, m_acc;

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tlast  = (state == ST_EMIT) && (fill == ONE);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  always_comb begin
    state_next = state;
    fill_next  = fill;
    pass_next  = pass;
    cmd        = '{load: 1'b0, step: 1'b0, phase: pass[0], shift: 1'b0, count: fill};
    unique case (state)
      ST_LOAD: begin
        if (s_acc) begin
          cmd.load  = 1'b1;
          fill_next = fill + ONE;
          pass_next = '0;
          if (s_tlast || fill + ONE == FULL) begin
            state_next = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        cmd.step  = 1'b1;
        pass_next = pass + ONE;
        if (pass + ONE == fill) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_acc) begin
          cmd.shift = 1'b1;
          fill_next = fill - ONE;
          if (fill == ONE) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
        fill_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill  <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pass  <= pass_next;
    end
  end

  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output open at once");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count beyond batch size");

  a_sort_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT) |-> (fill != '0) && (pass < fill))
    else $error("sort pass with empty batch or pass overrun");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready && (fill == '0))
    else $error("batch end did not return to load");

endmodule

// ===== rtl/core/batch_key_index_sort.sv =====
`timescale 1ns / 1ps
// Top level of the batch key/index sorter; instantiates bkis_ctrl and
// bkis_datapath, types from bkis_pkg.
//
// Collects a batch of 80-bit keys, one word per cycle while s_tvalid holds,
// numbering them 0, 1, 2, ... in arrival order. The batch closes on a word
// with tlast set or on the BATCH-th key. The block then sorts the batch
// ascending (unsigned compare of {key_high, key_low}, which is byte order of
// the 10-byte key) and sends every key back with its arrival index; equal
// keys keep arrival order. The last result word of a batch carries m_tlast.
// For a batch of n keys: the keys load (one key per cycle), then n
// odd-even transposition passes run over the cell row (one pass per cycle,
// all neighbor pairs of one parity compared at once), then n output words
// leave at one per cycle while m_tready holds. Input is taken only while
// loading; the next batch starts loading the cycle after the last result
// word is taken.
module batch_key_index_sort #(
  parameter int BATCH = 64   // keys per full batch, 2 to 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [63:0] key_high, [79:64] key_low
  input  logic [bkis_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tlast,    // last key of batch
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [5:0] entry_index, [69:6] sorted_high, [85:70] sorted_low, [87:86] zero
  output logic [bkis_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast     // final_res
);

  bkis_pkg::cmd_t   cmd;
  bkis_pkg::entry_t head;

  bkis_ctrl #(
    .BATCH(BATCH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd)
  );

  bkis_datapath #(
    .BATCH(BATCH)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .key_high (s_tdata[bkis_pkg::HIGH_W-1:0]),
    .key_low  (s_tdata[bkis_pkg::KEY_W-1:bkis_pkg::HIGH_W]),
    .head     (head)
  );

  // head cell is a register; key is {high, low}, so low sits in the bottom bits
  assign m_tdata = {{bkis_pkg::M_PAD_W{1'b0}},
                    head.key[bkis_pkg::LOW_W-1:0],
                    head.key[bkis_pkg::KEY_W-1:bkis_pkg::LOW_W],
                    head.idx};

endmodule
